// ===== hw/rtl/edus_pkg.sv =====
// shared widths, constants and wave packet types for the earliest deadline unit server
package edus_pkg;

	localparam int CNT_W     = 16;
	localparam int LIFE_W    = 16;
	localparam int TICK_W    = 32;
	localparam int EXP_W     = 33;
	localparam int TOT_W     = 32;
	localparam int DEPTH_DEF = 64;

	// pending arrival carried along the chain until a free slot takes it
	typedef struct packed {
		logic              pend;
		logic [EXP_W-1:0]  expiry;
		logic [CNT_W-1:0]  cnt;
	} edus_store_t;

	// running earliest live batch seen so far by the wave
	typedef struct packed {
		logic              found;
		logic [EXP_W-1:0]  expiry;
		logic [CNT_W-1:0]  rem;
	} edus_best_t;

endpackage

// ===== hw/rtl/edus_cell.sv =====
// one batch slot of the chain: store, purge, running minimum, serve decrement
module edus_cell #(
	parameter int DEPTH    = edus_pkg::DEPTH_DEF,
	parameter int CELL_IDX = 0,
	parameter int IW       = $clog2(DEPTH),
	parameter int CW       = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [edus_pkg::TICK_W-1:0]   tick,
	input  logic                          act_in,
	input  edus_pkg::edus_store_t         store_in,
	input  edus_pkg::edus_best_t          best_in,
	input  logic [IW-1:0]                 idx_in,
	input  logic [CW-1:0]                 live_in,
	output logic                          act_out,
	output edus_pkg::edus_store_t         store_out,
	output edus_pkg::edus_best_t          best_out,
	output logic [IW-1:0]                 idx_out,
	output logic [CW-1:0]                 live_out,
	input  logic                          serve_en,
	input  logic [IW-1:0]                 serve_idx
);
	import edus_pkg::*;

	logic              valid_q;
	logic [EXP_W-1:0]  exp_q;
	logic [CNT_W-1:0]  rem_q;
	logic              act_q;
	edus_store_t       store_q;
	edus_best_t        best_q;
	logic [IW-1:0]     idx_q;
	logic [CW-1:0]     live_q;

	logic              v_n;
	logic [EXP_W-1:0]  e_n;
	logic [CNT_W-1:0]  r_n;
	edus_store_t       st_n;
	edus_best_t        bst_n;
	logic [IW-1:0]     idx_n;
	logic              serve_hit;

	assign serve_hit = serve_en && (serve_idx == IW'(CELL_IDX));

	always_comb begin
		v_n   = valid_q;
		e_n   = exp_q;
		r_n   = rem_q;
		st_n  = store_in;
		bst_n = best_in;
		idx_n = idx_in;
		// first free slot takes the arrival
		if (st_n.pend && !v_n) begin
			v_n       = 1'b1;
			e_n       = st_n.expiry;
			r_n       = st_n.cnt;
			st_n.pend = 1'b0;
		end
		// expired or empty batches drop out
		if (v_n && ((e_n <= {1'b0, tick}) || (r_n == '0))) begin
			v_n = 1'b0;
		end
		// strict less keeps the lower slot on equal expiry
		if (v_n && (!bst_n.found || (e_n < bst_n.expiry))) begin
			bst_n.found  = 1'b1;
			bst_n.expiry = e_n;
			bst_n.rem    = r_n;
			idx_n        = IW'(CELL_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			act_q   <= 1'b0;
		end else begin
			act_q <= act_in;
			if (act_in) begin
				valid_q <= v_n;
			end else if (serve_hit && (rem_q == CNT_W'(1))) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act_in) begin
			exp_q   <= e_n;
			rem_q   <= r_n;
			store_q <= st_n;
			best_q  <= bst_n;
			idx_q   <= idx_n;
			live_q  <= live_in + CW'(v_n);
		end else if (serve_hit) begin
			rem_q <= rem_q - CNT_W'(1);
		end
	end

	assign act_out   = act_q;
	assign store_out = store_q;
	assign best_out  = best_q;
	assign idx_out   = idx_q;
	assign live_out  = live_q;

endmodule

// ===== hw/rtl/earliest_deadline_unit_server_core.sv =====
// top level: tick sequencer, output register and the row of batch slot cells
// a tick beat is taken only in idle; its wave passes the head register and each slot cell
// in turn, and the next tick waits until the result beat is loaded into the output register
// a result may wait in the output register while the next tick is taken
// reset (arst_n low) clears tick count, total, occupancy and all slot valid bits
// slot payloads hold no reset value and are only read behind their valid bit
module earliest_deadline_unit_server_core #(
	parameter int DEPTH = edus_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [edus_pkg::CNT_W-1:0]    arrive_count,
	input  logic [edus_pkg::LIFE_W-1:0]   lifetime,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          served,
	output logic [edus_pkg::TOT_W-1:0]    total_served,
	output logic                          store_empty,
	output logic                          dropped
);
	import edus_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [TICK_W-1:0] tick_q;
	logic [TOT_W-1:0]  tot_q;
	logic [CW-1:0]     occ_q;
	logic              drop_q;

	// head of the chain: launch packet for the wave
	logic              head_act_q;
	edus_store_t       head_store_q;

	logic              out_valid_q;
	logic              out_served_q;
	logic              out_drop_q;

	// chain links, link i feeds cell i
	logic              act_l   [DEPTH+1];
	edus_store_t       store_l [DEPTH+1];
	edus_best_t        best_l  [DEPTH+1];
	logic [IW-1:0]     idx_l   [DEPTH+1];
	logic [CW-1:0]     live_l  [DEPTH+1];

	logic              in_fire;
	logic              out_free;
	logic              finish;
	logic              serve_en;
	logic              arrival;
	logic              full;
	logic [CW-1:0]     occ_n;

	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign finish   = (state_q == ST_DONE) && out_free;
	assign serve_en = finish && best_l[DEPTH].found;
	assign arrival  = (arrive_count != '0);
	assign full     = (occ_q == CW'(DEPTH));

	// batch served down to nothing leaves the store
	assign occ_n = live_l[DEPTH]
		- CW'(best_l[DEPTH].found && (best_l[DEPTH].rem == CNT_W'(1)));

	assign act_l[0]   = head_act_q;
	assign store_l[0] = head_store_q;
	assign best_l[0]  = '0;
	assign idx_l[0]   = '0;
	assign live_l[0]  = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		edus_cell #(
			.DEPTH    (DEPTH),
			.CELL_IDX (i),
			.IW       (IW),
			.CW       (CW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tick      (tick_q),
			.act_in    (act_l[i]),
			.store_in  (store_l[i]),
			.best_in   (best_l[i]),
			.idx_in    (idx_l[i]),
			.live_in   (live_l[i]),
			.act_out   (act_l[i+1]),
			.store_out (store_l[i+1]),
			.best_out  (best_l[i+1]),
			.idx_out   (idx_l[i+1]),
			.live_out  (live_l[i+1]),
			.serve_en  (serve_en),
			.serve_idx (idx_l[DEPTH])
		);
	end

	// sequencer: take a tick, walk the chain, then serve and report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tick_q       <= '0;
			tot_q        <= '0;
			occ_q        <= '0;
			head_act_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// launch pulse only in the cycle after a tick is taken
			head_act_q  <= in_fire;
			// result beat held until taken, new one loaded when the wave finishes
			out_valid_q <= finish || (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (act_l[DEPTH]) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						occ_q <= occ_n;
						if (best_l[DEPTH].found && (tot_q != '1)) begin
							tot_q <= tot_q + TOT_W'(1);
						end
						if (tick_q != '1) begin
							tick_q <= tick_q + TICK_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			drop_q              <= arrival && full;
			head_store_q.pend   <= arrival && !full;
			head_store_q.expiry <= {1'b0, tick_q} + EXP_W'(lifetime);
			head_store_q.cnt    <= arrive_count;
		end
		if (finish) begin
			out_served_q <= best_l[DEPTH].found;
			out_drop_q   <= drop_q;
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign served       = out_served_q;
	assign total_served = tot_q;
	assign store_empty  = (occ_q == '0);
	assign dropped      = out_drop_q;

endmodule

// ===== hw/rtl/edus_checker.sv =====
// port level checks for the earliest deadline unit server, bound to the top level
module edus_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          served,
	input  logic [edus_pkg::TOT_W-1:0]    total_served,
	input  logic                          store_empty,
	input  logic                          dropped
);
	import edus_pkg::*;

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(total_served)
			&& $stable(served) && $stable(dropped) && $stable(store_empty))
		else $error("result beat changed while stalled");

	// one tick at a time: taking a beat closes the input
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second tick taken while one is in flight");

	// a new result frees the input side
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("input still stalled when result appears");

	// nothing served means no live batch remained
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !served |-> store_empty)
		else $error("no unit served but store not empty");

endmodule

bind earliest_deadline_unit_server_core edus_checker u_edus_checker (.*);
